// ----- design/tql_pkg.sv -----
// Shared types and constants for the tabular Q-learning engine.
// Used by the top level, tql_front, tql_back and the testbench; no dependencies.
package tql_pkg;

    localparam int CONTEXTS_DEF = 16;
    localparam int STATES_DEF   = 1024;
    localparam int ACTIONS_DEF  = 4;

    localparam int VAL_W  = 40;
    localparam int SUM_W  = 42;
    localparam int ACC_W  = 58;
    localparam int LIM_W  = 36;
    localparam int RATE_W = 17;
    localparam int EPS_W  = 54;
    localparam int MASK_W = 4;

    localparam logic [63:0] SM_GOLDEN = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] SM_MUL1   = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] SM_MUL2   = 64'h94d049bb133111eb;

    localparam logic [2:0] REG_LEARN   = 3'd0;
    localparam logic [2:0] REG_DISC    = 3'd1;
    localparam logic [2:0] REG_EXPLORE = 3'd2;
    localparam logic [2:0] REG_RLIM    = 3'd3;
    localparam logic [2:0] REG_VLIM    = 3'd4;
    localparam logic [2:0] REG_FROZEN  = 3'd5;

    typedef enum logic [1:0] {
        STAT_DONE     = 2'd0,
        STAT_NO_LEGAL = 2'd1,
        STAT_FROZEN   = 2'd2
    } t_status;

    typedef struct packed {
        logic                    is_upd;
        logic                    term;
        logic                    train;
        logic [1:0]              act;
        logic [MASK_W-1:0]       mask;
        logic [63:0]             seed;
        logic signed [VAL_W-1:0] reward;
    } t_hdr;

    typedef struct packed {
        logic [RATE_W-1:0] learn;
        logic [RATE_W-1:0] disc;
        logic [EPS_W-1:0]  eps;
        logic [LIM_W-1:0]  rlim;
        logic [LIM_W-1:0]  vlim;
        logic              frozen;
    } t_cfg;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_CH_SEL, S_SM_INIT, S_SM_MUL, S_SM_USE, S_MOD3,
        S_UP_BOOT, S_G_LO, S_G_HI, S_UP_TGT, S_UP_DIFF, S_A_LO, S_A_HI, S_UP_WR
    } t_bstate;

endpackage

// ----- design/tabular_q_learning_engine.sv -----
// Top level of the tabular Q-learning engine: stream ports, register file, wiring.
// Depends on tql_pkg, tql_front, tql_queue and tql_back.
//
//  Port group   Direction  Contents
//  s_t*         in         request item; tuser = req_type, tlast = terminal
//  m_t*         out        result item; tdata = status, chosen_action
//  APB          in/out     six registers at byte address 8*i, 64-bit data
//
// A choose passes through S_IDLE and S_CH_SEL in the back end; each random draw
// runs on the 32x32 multiplier, and a pick among three legal actions adds a mod-3 pass.
// An update does two table reads, two two-pass multiplies and one write; a refused
// update is answered from S_IDLE.
// After reset a clearing pass zeroes every row of the table, with s_tready low.
// A two-item queue lets requests enter while the back end works and a result
// waits on m_tready.
module tabular_q_learning_engine #(
    parameter int CONTEXTS = tql_pkg::CONTEXTS_DEF,
    parameter int STATES   = tql_pkg::STATES_DEF,
    parameter int ACTIONS  = tql_pkg::ACTIONS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // context_id, state_index, action, allowed_mask, training, mixed_seed,
    // reward, next_state, one zero pad bit
    input  logic [135:0] s_tdata,
    // req_type
    input  logic         s_tuser,
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    // status, chosen_action, four zero pad bits
    output logic [7:0]   m_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [5:0]   paddr,
    input  logic [63:0]  pwdata,
    output logic [63:0]  prdata,
    output logic         pready
);
    import tql_pkg::*;

    localparam int ROW_W = $clog2(CONTEXTS * STATES);
    localparam int Q_W   = $bits(t_hdr) + 2 * ROW_W;

    t_cfg             r_cfg;
    t_hdr             f_hdr, q_hdr;
    logic [ROW_W-1:0] f_row, f_nrow, q_row, q_nrow;
    logic             push, full, pop, qvalid, clearing;
    logic [1:0]       res_st, res_act;
    logic [Q_W-1:0]   q_out;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.learn  <= RATE_W'(6554);
            r_cfg.disc   <= RATE_W'(62259);
            r_cfg.eps    <= '0;
            r_cfg.rlim   <= LIM_W'(65536);
            r_cfg.vlim   <= LIM_W'(6553600);
            r_cfg.frozen <= 1'b0;
        end else if (psel && penable && pwrite) begin
            case (paddr[5:3])
                REG_LEARN:   r_cfg.learn  <= pwdata[RATE_W-1:0];
                REG_DISC:    r_cfg.disc   <= pwdata[RATE_W-1:0];
                REG_EXPLORE: r_cfg.eps    <= pwdata[EPS_W-1:0];
                REG_RLIM:    r_cfg.rlim   <= pwdata[LIM_W-1:0];
                REG_VLIM:    r_cfg.vlim   <= pwdata[LIM_W-1:0];
                REG_FROZEN:  r_cfg.frozen <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[5:3])
            REG_LEARN:   prdata = 64'(r_cfg.learn);
            REG_DISC:    prdata = 64'(r_cfg.disc);
            REG_EXPLORE: prdata = 64'(r_cfg.eps);
            REG_RLIM:    prdata = 64'(r_cfg.rlim);
            REG_VLIM:    prdata = 64'(r_cfg.vlim);
            REG_FROZEN:  prdata = 64'(r_cfg.frozen);
            default:     prdata = '0;
        endcase
    end

    tql_front #(
        .CONTEXTS(CONTEXTS), .STATES(STATES), .ACTIONS(ACTIONS), .ROW_W(ROW_W)
    ) u_front (
        .i_valid   (s_tvalid),
        .i_data    (s_tdata),
        .i_user    (s_tuser),
        .i_last    (s_tlast),
        .o_ready   (s_tready),
        .i_clearing(clearing),
        .i_full    (full),
        .o_push    (push),
        .o_hdr     (f_hdr),
        .o_row     (f_row),
        .o_nrow    (f_nrow)
    );

    tql_queue #(.DATA_W(Q_W)) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_data ({f_hdr, f_row, f_nrow}),
        .o_full (full),
        .i_pop  (pop),
        .o_valid(qvalid),
        .o_data (q_out)
    );

    assign {q_hdr, q_row, q_nrow} = q_out;

    tql_back #(
        .CONTEXTS(CONTEXTS), .STATES(STATES), .ACTIONS(ACTIONS), .ROW_W(ROW_W)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_qvalid  (qvalid),
        .i_hdr     (q_hdr),
        .i_row     (q_row),
        .i_nrow    (q_nrow),
        .o_pop     (pop),
        .o_clearing(clearing),
        .o_valid   (m_tvalid),
        .i_ready   (m_tready),
        .o_status  (res_st),
        .o_act     (res_act)
    );

    assign m_tdata = {4'd0, res_act, res_st};
endmodule

// ----- design/tql_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
module tql_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ----- design/tql_queue.sv -----
// Two-entry queue that decouples the request front end from the back end.
// No dependencies.
module tql_queue #(
    parameter int DATA_W = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_valid,
    output logic [DATA_W-1:0] o_data
);
    logic [DATA_W-1:0] r_mem [2];
    logic              r_wp, r_rp;
    logic [1:0]        r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    assign o_full  = r_cnt[1];
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];
endmodule

// ----- design/tql_front.sv -----
// Request front end: unpacks stream items, wraps indexes and forms table rows.
// Depends on tql_pkg; feeds tql_queue.
module tql_front #(
    parameter int CONTEXTS = tql_pkg::CONTEXTS_DEF,
    parameter int STATES   = tql_pkg::STATES_DEF,
    parameter int ACTIONS  = tql_pkg::ACTIONS_DEF,
    parameter int ROW_W    = $clog2(CONTEXTS * STATES)
) (
    input  logic             i_valid,
    input  logic [135:0]     i_data,
    input  logic             i_user,
    input  logic             i_last,
    output logic             o_ready,
    input  logic             i_clearing,
    input  logic             i_full,
    output logic             o_push,
    output tql_pkg::t_hdr    o_hdr,
    output logic [ROW_W-1:0] o_row,
    output logic [ROW_W-1:0] o_nrow
);
    import tql_pkg::*;

    localparam logic [MASK_W-1:0] ACT_MASK = MASK_W'((1 << ACTIONS) - 1);

    function automatic logic [9:0] wrap_st(input logic [9:0] x);
        logic [10:0] r;
        r = '0;
        if (STATES >= 1024) begin
            r = {1'b0, x};
        end else begin
            for (int i = 9; i >= 0; i--) begin
                r = {r[9:0], x[i]};
                if (r >= 11'(STATES)) begin
                    r = r - 11'(STATES);
                end
            end
        end
        return r[9:0];
    endfunction

    function automatic logic [3:0] wrap_ctx(input logic [3:0] x);
        logic [4:0] r;
        r = '0;
        if (CONTEXTS >= 16) begin
            r = {1'b0, x};
        end else begin
            for (int i = 3; i >= 0; i--) begin
                r = {r[3:0], x[i]};
                if (r >= 5'(CONTEXTS)) begin
                    r = r - 5'(CONTEXTS);
                end
            end
        end
        return r[3:0];
    endfunction

    logic [3:0] ctx_w;
    logic [9:0] st, nst;

    assign st    = i_data[13:4];
    assign nst   = i_data[134:125];
    assign ctx_w = wrap_ctx(i_data[3:0]);

    assign o_ready = !i_full && !i_clearing;
    assign o_push  = i_valid && o_ready;

    always_comb begin
        o_hdr.is_upd = i_user;
        o_hdr.term   = i_last;
        o_hdr.train  = i_data[20];
        o_hdr.act    = i_data[15:14];
        o_hdr.mask   = i_data[19:16] & ACT_MASK;
        o_hdr.seed   = i_data[84:21] ^ {54'd0, st};
        o_hdr.reward = $signed(i_data[124:85]);
        o_row  = ROW_W'(ROW_W'(ctx_w) * ROW_W'(STATES) + ROW_W'(wrap_st(st)));
        o_nrow = ROW_W'(ROW_W'(ctx_w) * ROW_W'(STATES) + ROW_W'(wrap_st(nst)));
    end
endmodule

// ----- design/tql_back.sv -----
// Back end: owns the Q-table, runs greedy choice, exploration and value updates.
// Depends on tql_pkg and tql_ram.
module tql_back #(
    parameter int CONTEXTS = tql_pkg::CONTEXTS_DEF,
    parameter int STATES   = tql_pkg::STATES_DEF,
    parameter int ACTIONS  = tql_pkg::ACTIONS_DEF,
    parameter int ROW_W    = $clog2(CONTEXTS * STATES)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  tql_pkg::t_cfg    i_cfg,
    input  logic             i_qvalid,
    input  tql_pkg::t_hdr    i_hdr,
    input  logic [ROW_W-1:0] i_row,
    input  logic [ROW_W-1:0] i_nrow,
    output logic             o_pop,
    output logic             o_clearing,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [1:0]       o_status,
    output logic [1:0]       o_act
);
    import tql_pkg::*;

    localparam int ROWS  = CONTEXTS * STATES;
    localparam int RW    = ACTIONS * VAL_W;

    t_bstate                  r_state, n_state;
    t_hdr                     r_hdr, n_hdr;
    logic [ROW_W-1:0]         r_row, n_row, r_clr, n_clr;
    logic [RW-1:0]            r_rowd, n_rowd;
    logic signed [VAL_W-1:0]  r_ma, n_ma, r_v, n_v;
    logic [RATE_W-1:0]        r_mf, n_mf;
    logic signed [ACC_W-1:0]  r_acc, n_acc;
    logic signed [SUM_W-1:0]  r_tgt, n_tgt;
    logic [1:0]               r_best, n_best, r_step, n_step, r_mr, n_mr;
    logic                     r_round, n_round, r_phase, n_phase;
    logic [63:0]              r_s, n_s, r_x, n_x, r_macc, n_macc, r_w, n_w;
    logic [2:0]               r_n, n_n;
    logic [4:0]               r_mcnt, n_mcnt;
    logic                     r_ovalid, n_ovalid;
    logic [1:0]               r_ost, n_ost, r_oact, n_oact;

    logic                     we, pop_ok;
    logic [ROW_W-1:0]         waddr, raddr;
    logic [RW-1:0]            wdata, rdata;
    logic signed [20:0]       mop;
    logic signed [38:0]       prod;
    logic signed [SUM_W-1:0]  sc;
    logic [63:0]              p64, macc_nxt, sm_c;
    logic [31:0]              a32, b32;

    tql_ram #(.WIDTH(RW), .DEPTH(ROWS)) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_re   (1'b1),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    function automatic logic signed [VAL_W-1:0] slot(input logic [RW-1:0] d,
                                                    input logic [1:0] a);
        logic signed [VAL_W-1:0] v;
        v = '0;
        for (int i = 0; i < ACTIONS; i++) begin
            if (a == 2'(i)) begin
                v = d[i*VAL_W +: VAL_W];
            end
        end
        return v;
    endfunction

    // Returns {found, index} of the first maximum among allowed actions.
    function automatic logic [2:0] greedy(input logic [RW-1:0] d,
                                          input logic [MASK_W-1:0] m);
        logic                    f;
        logic [1:0]              b;
        logic signed [VAL_W-1:0] bv, cv;
        f  = 1'b0;
        b  = '0;
        bv = '0;
        for (int i = 0; i < ACTIONS; i++) begin
            cv = d[i*VAL_W +: VAL_W];
            if (m[i] && (!f || cv > bv)) begin
                f  = 1'b1;
                b  = 2'(i);
                bv = cv;
            end
        end
        return {f, b};
    endfunction

    function automatic logic [2:0] count_legal(input logic [MASK_W-1:0] m);
        logic [2:0] c;
        c = '0;
        for (int i = 0; i < ACTIONS; i++) begin
            c = c + 3'(m[i]);
        end
        return c;
    endfunction

    function automatic logic [1:0] pick(input logic [MASK_W-1:0] m, input logic [1:0] k);
        logic [2:0] c;
        logic [1:0] r;
        c = '0;
        r = '0;
        for (int i = 0; i < ACTIONS; i++) begin
            if (m[i]) begin
                if (c == {1'b0, k}) begin
                    r = 2'(i);
                end
                c = c + 3'd1;
            end
        end
        return r;
    endfunction

    function automatic logic signed [SUM_W-1:0] clamp(input logic signed [SUM_W-1:0] v,
                                                     input logic [LIM_W-1:0] lim);
        logic signed [SUM_W-1:0] l;
        l = $signed({{(SUM_W-LIM_W){1'b0}}, lim});
        if (v > l) begin
            return l;
        end
        if (v < -l) begin
            return -l;
        end
        return v;
    endfunction

    assign mop  = (r_state == S_G_LO || r_state == S_A_LO) ? $signed({1'b0, r_ma[19:0]})
                                                          : $signed({r_ma[39], r_ma[39:20]});
    assign prod = mop * $signed({1'b0, r_mf});
    assign sc   = SUM_W'((r_acc + ACC_W'(32768)) >>> 16);

    assign sm_c     = r_round ? SM_MUL2 : SM_MUL1;
    assign a32      = (r_step == 2'd1) ? r_x[63:32] : r_x[31:0];
    assign b32      = (r_step == 2'd2) ? sm_c[63:32] : sm_c[31:0];
    assign p64      = a32 * b32;
    assign macc_nxt = (r_step == 2'd0) ? p64 : r_macc + {p64[31:0], 32'd0};

    assign pop_ok     = (r_state == S_IDLE) && i_qvalid && (!r_ovalid || i_ready);
    assign o_pop      = pop_ok;
    assign o_clearing = (r_state == S_CLEAR);
    assign o_valid    = r_ovalid;
    assign o_status   = r_ost;
    assign o_act      = r_oact;

    always_comb begin
        logic       fin;
        logic [1:0] fst, fact, k;
        logic [2:0] g, s3;
        logic [63:0] t64;
        logic signed [SUM_W-1:0] rc;
        n_state = r_state;  n_hdr = r_hdr;     n_row = r_row;   n_clr = r_clr;
        n_rowd = r_rowd;    n_ma = r_ma;       n_v = r_v;       n_mf = r_mf;
        n_acc = r_acc;      n_tgt = r_tgt;     n_best = r_best; n_step = r_step;
        n_mr = r_mr;        n_round = r_round; n_phase = r_phase;
        n_s = r_s;          n_x = r_x;         n_macc = r_macc; n_w = r_w;
        n_n = r_n;          n_mcnt = r_mcnt;
        fin = 1'b0;  fst = STAT_DONE;  fact = '0;  k = '0;  g = '0;  s3 = '0;
        t64 = '0;  rc = '0;
        we = 1'b0;  waddr = r_row;  wdata = r_rowd;  raddr = r_row;

        case (r_state)
            S_CLEAR: begin
                we    = 1'b1;
                waddr = r_clr;
                wdata = '0;
                n_clr = r_clr + ROW_W'(1);
                if (r_clr == ROW_W'(ROWS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                raddr = (i_hdr.is_upd) ? i_nrow : i_row;
                if (pop_ok) begin
                    n_hdr = i_hdr;
                    n_row = i_row;
                    if (!i_hdr.is_upd) begin
                        n_state = S_CH_SEL;
                    end else if (i_cfg.frozen) begin
                        fin = 1'b1;
                        fst = STAT_FROZEN;
                    end else if ({1'b0, i_hdr.act} >= 3'(ACTIONS)) begin
                        fin = 1'b1;
                        fst = STAT_NO_LEGAL;
                    end else if (i_hdr.term) begin
                        n_ma    = '0;
                        n_mf    = i_cfg.disc;
                        n_state = S_G_LO;
                    end else begin
                        n_state = S_UP_BOOT;
                    end
                end
            end
            S_CH_SEL: begin
                g = greedy(rdata, r_hdr.mask);
                if (!g[2]) begin
                    fin     = 1'b1;
                    fst     = STAT_NO_LEGAL;
                    n_state = S_IDLE;
                end else if (r_hdr.train && !i_cfg.frozen && i_cfg.eps != '0) begin
                    n_best  = g[1:0];
                    n_s     = r_hdr.seed;
                    n_phase = 1'b0;
                    n_n     = count_legal(r_hdr.mask);
                    n_state = S_SM_INIT;
                end else begin
                    fin     = 1'b1;
                    fact    = g[1:0];
                    n_state = S_IDLE;
                end
            end
            S_SM_INIT: begin
                t64     = r_s + SM_GOLDEN;
                n_s     = t64;
                n_x     = t64 ^ (t64 >> 30);
                n_step  = '0;
                n_round = 1'b0;
                n_state = S_SM_MUL;
            end
            S_SM_MUL: begin
                if (r_step != 2'd2) begin
                    n_macc = macc_nxt;
                    n_step = r_step + 2'd1;
                end else if (!r_round) begin
                    n_x     = macc_nxt ^ (macc_nxt >> 27);
                    n_round = 1'b1;
                    n_step  = '0;
                end else begin
                    n_w     = macc_nxt ^ (macc_nxt >> 31);
                    n_state = S_SM_USE;
                end
            end
            S_SM_USE: begin
                if (!r_phase) begin
                    if ({1'b0, r_w[63:11]} < i_cfg.eps) begin
                        n_phase = 1'b1;
                        n_state = S_SM_INIT;
                    end else begin
                        fin     = 1'b1;
                        fact    = r_best;
                        n_state = S_IDLE;
                    end
                end else if (r_n == 3'd3 && r_w == '0) begin
                    n_state = S_SM_INIT;
                end else if (r_n == 3'd3) begin
                    n_mr    = '0;
                    n_mcnt  = '0;
                    n_state = S_MOD3;
                end else begin
                    k       = (r_n == 3'd4) ? r_w[1:0] : (r_n == 3'd2) ? {1'b0, r_w[0]} : 2'd0;
                    fin     = 1'b1;
                    fact    = pick(r_hdr.mask, k);
                    n_state = S_IDLE;
                end
            end
            S_MOD3: begin
                s3     = {1'b0, r_mr} + {1'b0, r_w[63:62]};
                k      = (s3 >= 3'd3) ? 2'(s3 - 3'd3) : s3[1:0];
                n_mr   = k;
                n_w    = {r_w[61:0], 2'b00};
                n_mcnt = r_mcnt + 5'd1;
                if (r_mcnt == 5'd31) begin
                    fin     = 1'b1;
                    fact    = pick(r_hdr.mask, k);
                    n_state = S_IDLE;
                end
            end
            S_UP_BOOT: begin
                g       = greedy(rdata, r_hdr.mask);
                n_ma    = g[2] ? slot(rdata, g[1:0]) : '0;
                n_mf    = i_cfg.disc;
                n_state = S_G_LO;
            end
            S_G_LO, S_A_LO: begin
                n_acc   = ACC_W'(prod);
                n_state = (r_state == S_G_LO) ? S_G_HI : S_A_HI;
            end
            S_G_HI, S_A_HI: begin
                n_acc   = r_acc + (ACC_W'(prod) <<< 20);
                n_state = (r_state == S_G_HI) ? S_UP_TGT : S_UP_WR;
            end
            S_UP_TGT: begin
                rc      = clamp(SUM_W'(r_hdr.reward), i_cfg.rlim);
                n_tgt   = clamp(rc + sc, i_cfg.vlim);
                n_state = S_UP_DIFF;
            end
            S_UP_DIFF: begin
                n_v     = slot(rdata, r_hdr.act);
                n_rowd  = rdata;
                n_ma    = VAL_W'(r_tgt - SUM_W'(slot(rdata, r_hdr.act)));
                n_mf    = i_cfg.learn;
                n_state = S_A_LO;
            end
            S_UP_WR: begin
                rc = clamp(SUM_W'(r_v) + sc, i_cfg.vlim);
                for (int i = 0; i < ACTIONS; i++) begin
                    if (r_hdr.act == 2'(i)) begin
                        wdata[i*VAL_W +: VAL_W] = VAL_W'(rc);
                    end
                end
                we      = 1'b1;
                fin     = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_ovalid = r_ovalid && !i_ready;
        n_ost    = r_ost;
        n_oact   = r_oact;
        if (fin) begin
            n_ovalid = 1'b1;
            n_ost    = fst;
            n_oact   = fact;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_ovalid <= n_ovalid;
        end
        r_hdr <= n_hdr;    r_row <= n_row;     r_rowd <= n_rowd;   r_ma <= n_ma;
        r_v <= n_v;        r_mf <= n_mf;       r_acc <= n_acc;     r_tgt <= n_tgt;
        r_best <= n_best;  r_step <= n_step;   r_mr <= n_mr;       r_round <= n_round;
        r_phase <= n_phase; r_s <= n_s;        r_x <= n_x;         r_macc <= n_macc;
        r_w <= n_w;        r_n <= n_n;         r_mcnt <= n_mcnt;   r_ost <= n_ost;
        r_oact <= n_oact;
    end
endmodule

// ----- tb/testbench.sv -----
// Testbench for the tabular Q-learning engine: random and directed choose/update items,
// checked against an in-bench model of the Q-table. Depends on tql_pkg and the RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import tql_pkg::*;

    typedef struct {
        bit        is_upd;
        bit [3:0]  ctx;
        bit [9:0]  st;
        bit [1:0]  act;
        bit [3:0]  mask;
        bit        train;
        bit [63:0] seed;
        bit [39:0] reward;
        bit [9:0]  nst;
        bit        term;
    } t_req;

    typedef struct {
        bit [1:0] status;
        bit [1:0] choice;
    } t_outcome;

    int err_count = 0;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH: %s", msg);
        err_count++;
    endtask

    class q_scoreboard;
        longint q_vals [int];
        bit [16:0] alpha = 6554;
        bit [16:0] gamma = 62259;
        bit [53:0] eps = 0;
        bit [35:0] rlim = 65536;
        bit [35:0] vlim = 6553600;
        bit        frz = 0;
        t_outcome  pending[$];

        function longint qv(int row, int a);
            int k;
            k = row * 4 + a;
            return q_vals.exists(k) ? q_vals[k] : 0;
        endfunction

        function void set_reg(int idx, bit [63:0] v);
            case (idx)
                REG_LEARN: alpha = v[16:0];
                REG_DISC: gamma = v[16:0];
                REG_EXPLORE: eps = v[53:0];
                REG_RLIM: rlim = v[35:0];
                REG_VLIM: vlim = v[35:0];
                REG_FROZEN: frz = v[0];
                default: ;
            endcase
        endfunction

        function bit [63:0] mix_next(ref bit [63:0] s);
            bit [63:0] x;
            s = s + SM_GOLDEN;
            x = s;
            x = (x ^ (x >> 30)) * SM_MUL1;
            x = (x ^ (x >> 27)) * SM_MUL2;
            return x ^ (x >> 31);
        endfunction

        function longint clamp(longint v, bit [35:0] lim);
            longint l;
            l = longint'(lim);
            if (v > l) return l;
            if (v < -l) return -l;
            return v;
        endfunction

        function longint scale16(longint a, bit [16:0] f);
            longint p;
            p = a * longint'(f) + 32768;
            return p >>> 16;
        endfunction

        function int best_of(int row, bit [3:0] mask);
            int b;
            b = -1;
            for (int a = 0; a < 4; a++)
                if (mask[a] && (b < 0 || qv(row, a) > qv(row, b))) b = a;
            return b;
        endfunction

        function void note_request(t_req r);
            t_outcome o;
            int row, nrow, b, n;
            int legal[4];
            bit [63:0] s, w, thr;
            longint boot, tgt, v;
            o.status = STAT_DONE;
            o.choice = 0;
            row = r.ctx * 1024 + r.st;
            if (!r.is_upd) begin
                b = best_of(row, r.mask);
                if (b < 0) begin
                    o.status = STAT_NO_LEGAL;
                end else begin
                    if (r.train && !frz && eps != 0) begin
                        s = r.seed ^ 64'(r.st);
                        if ((mix_next(s) >> 11) < 64'(eps)) begin
                            n = 0;
                            for (int a = 0; a < 4; a++)
                                if (r.mask[a]) begin
                                    legal[n] = a;
                                    n++;
                                end
                            thr = (64'd0 - 64'(n)) % 64'(n);
                            w = mix_next(s);
                            while (w < thr) w = mix_next(s);
                            b = legal[w % 64'(n)];
                        end
                    end
                    o.choice = b[1:0];
                end
            end else if (frz) begin
                o.status = STAT_FROZEN;
            end else begin
                boot = 0;
                if (!r.term) begin
                    nrow = r.ctx * 1024 + r.nst;
                    b = best_of(nrow, r.mask);
                    if (b >= 0) boot = qv(nrow, b);
                end
                tgt = clamp(clamp(longint'(signed'(r.reward)), rlim) + scale16(boot, gamma),
                            vlim);
                v = qv(row, r.act);
                v = v + scale16(tgt - v, alpha);
                q_vals[row * 4 + r.act] = clamp(v, vlim);
            end
            pending.push_back(o);
        endfunction

        task check_result(bit [1:0] status, bit [1:0] choice);
            t_outcome e;
            if (pending.size() == 0) begin
                report_mismatch("result with nothing expected");
                return;
            end
            e = pending.pop_front();
            if (e.status != status)
                report_mismatch($sformatf("status %0d, expected %0d", status, e.status));
            if (e.choice != choice)
                report_mismatch($sformatf("action %0d, expected %0d", choice, e.choice));
        endtask
    endclass

    logic         i_clk = 0;
    logic         i_rst_n = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [135:0] s_tdata = 0;
    logic         s_tuser = 0;
    logic         s_tlast = 0;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [7:0]   m_tdata;
    logic         psel = 0;
    logic         penable = 0;
    logic         pwrite = 0;
    logic [5:0]   paddr = 0;
    logic [63:0]  pwdata = 0;
    logic [63:0]  prdata;
    logic         pready;

    q_scoreboard  qsb = new();
    longint       cycles = 0;
    int           stall_mode = 0;

    always begin
        #2 i_clk = 1;
        #2 i_clk = 0;
    end

    tabular_q_learning_engine dut (.*);

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 3000000) begin
            $display("FAIL tabular_q_learning_engine");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready)
            qsb.check_result(m_tdata[1:0], m_tdata[3:2]);
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 3) != 0);
            default: m_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    task automatic write_reg(input int idx, input bit [63:0] v);
        @(posedge i_clk);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= 6'(idx * 8);
        pwdata <= v;
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        qsb.set_reg(idx, v);
    endtask

    task automatic drain_results();
        while (qsb.pending.size() != 0) @(posedge i_clk);
        repeat (120) @(posedge i_clk);
    endtask

    task automatic send_request(input t_req r, input bit keep_valid);
        s_tvalid <= 1;
        s_tuser <= r.is_upd;
        s_tlast <= r.term;
        s_tdata <= {1'b0, r.nst, r.reward, r.seed, r.train, r.mask, r.act, r.st, r.ctx};
        do @(posedge i_clk); while (!s_tready);
        qsb.note_request(r);
        if (!keep_valid) begin
            s_tvalid <= 0;
            @(posedge i_clk);
        end
    endtask

    function automatic t_req random_request(int n_ctx, int n_st);
        t_req r;
        r.is_upd = 1'($urandom_range(0, 1));
        r.ctx = 4'($urandom_range(0, n_ctx - 1));
        r.st = (n_st == 1024) ? 10'($urandom) : 10'($urandom_range(0, n_st - 1));
        r.act = 2'($urandom);
        r.mask = ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'($urandom_range(1, 15));
        r.train = 1'($urandom);
        r.seed = {$urandom, $urandom};
        case ($urandom_range(0, 3))
            0: r.reward = 40'({$urandom, $urandom});
            1: r.reward = 40'($signed($urandom_range(0, 400000)) - 200000);
            default: r.reward = 40'($signed($urandom_range(0, 2000000)) - 1000000);
        endcase
        r.nst = (n_st == 1024) ? 10'($urandom) : 10'($urandom_range(0, n_st - 1));
        r.term = ($urandom_range(0, 3) == 0);
        return r;
    endfunction

    task automatic run_random(input int count);
        int burst;
        int k;
        t_req r;
        k = 0;
        while (k < count) begin
            burst = $urandom_range(1, 12);
            for (int j = 0; j < burst && k < count; j++) begin
                r = random_request(($urandom_range(0, 9) == 0) ? 16 : 2,
                                   ($urandom_range(0, 9) == 0) ? 1024 : 8);
                send_request(r, (j + 1 < burst) && (k + 1 < count));
                k++;
            end
            repeat ($urandom_range(0, 6)) @(posedge i_clk);
        end
    endtask

    initial begin
        t_req r;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;
        // directed items
        r = '{is_upd: 0, ctx: 0, st: 0, act: 0, mask: 4'hF, train: 0, seed: 0,
              reward: 0, nst: 0, term: 0};
        send_request(r, 0);
        r.mask = 0;
        send_request(r, 0);
        r.is_upd = 1; r.mask = 4'hF; r.reward = 40'h7FFFFFFFFF; r.term = 1;
        send_request(r, 0);
        r.act = 3; r.reward = 40'h8000000000; r.term = 0;
        send_request(r, 0);
        r.ctx = 15; r.st = 1023; r.nst = 1023; r.reward = 40'd100000; r.act = 2;
        send_request(r, 0);
        r.mask = 0; r.nst = 0;
        send_request(r, 0);
        r.is_upd = 0; r.mask = 4'hF; r.train = 1; r.seed = 64'hFFFFFFFFFFFFFFFF;
        send_request(r, 0);
        drain_results();
        write_reg(REG_EXPLORE, 64'd9007199254740992);
        write_reg(REG_LEARN, 64'd65536);
        write_reg(REG_DISC, 64'd65536);
        for (int m = 1; m < 16; m++) begin
            r.is_upd = 0; r.mask = 4'(m); r.seed = {$urandom, $urandom};
            send_request(r, 0);
        end
        r.is_upd = 1; r.reward = 40'd5000;
        send_request(r, 0);
        drain_results();
        write_reg(REG_FROZEN, 1);
        r.is_upd = 1;
        send_request(r, 0);
        r.is_upd = 0; r.train = 1;
        send_request(r, 0);
        drain_results();
        write_reg(REG_FROZEN, 0);
        write_reg(REG_EXPLORE, 64'd2251799813685248);
        write_reg(REG_LEARN, 64'd32768);
        write_reg(REG_DISC, 64'd58982);
        stall_mode = 1;
        run_random(600);
        drain_results();
        write_reg(REG_RLIM, 64'd65536000000);
        write_reg(REG_VLIM, 64'd65536000000);
        write_reg(REG_LEARN, 64'd1);
        write_reg(REG_DISC, 64'd0);
        write_reg(REG_EXPLORE, 64'd0);
        stall_mode = 2;
        run_random(600);
        drain_results();
        write_reg(REG_RLIM, 64'd1);
        write_reg(REG_VLIM, 64'd300000);
        write_reg(REG_LEARN, 64'd65536);
        write_reg(REG_DISC, 64'd65536);
        write_reg(REG_EXPLORE, 64'd4503599627370496);
        stall_mode = 0;
        run_random(600);
        drain_results();
        if (err_count == 0) begin
            $display("PASS tabular_q_learning_engine");
        end else begin
            $display("FAIL tabular_q_learning_engine");
        end
        $finish;
    end
endmodule
